// ===== rtl/core/dtem_pkg.sv =====
`timescale 1ns / 1ps

package dtem_pkg;

  // Field widths, sized to the largest value that any byte pattern can give
  localparam int unsigned YearW = 15;  // up to 16665
  localparam int unsigned MonW  = 8;   // up to 165
  localparam int unsigned DayW  = 8;   // up to 165
  localparam int unsigned MinW  = 14;  // up to 10065
  localparam int unsigned Q100W = 8;   // year / 100, up to 166
  localparam int unsigned OutW  = 32;

  localparam int unsigned DateW = 64;
  localparam int unsigned TimeW = 32;

  // Reciprocal of 100: x / 100 == (x * Recip100) >> Recip100Shift for x < 43690
  localparam int unsigned Recip100      = 5243;
  localparam int unsigned Recip100Shift = 19;
  localparam int unsigned Recip100W     = 13;

  localparam logic [OutW-1:0] DaysPerYear  = OutW'(365);
  localparam logic [OutW-1:0] YearZeroDays = OutW'(32'hFFFF_FE93);  // -365, wrapped
  localparam logic [OutW-1:0] MinPerDay    = OutW'(60 * 24);

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [MonW-1:0]  mon;
    logic [DayW-1:0]  mday;
    logic [MinW-1:0]  mins;
  } dec_t;

  typedef struct packed {
    logic             year_zero;
    logic [YearW-1:0] year;
    logic [YearW-1:0] rest;     // year - 1, held at zero for year zero
    logic [Q100W-1:0] rest_q100;
    logic [Q100W-1:0] year_q100;
    logic [MonW-1:0]  mon;
    logic [DayW-1:0]  mday;
    logic [MinW-1:0]  mins;
  } split_t;

  typedef struct packed {
    logic [OutW-1:0] days;
    logic [MinW-1:0] mins;
  } days_t;

  // Days before the first of the month; months outside one to twelve add zero
  function automatic logic [8:0] month_start(input logic leap, input logic [MonW-1:0] mon);
    logic [8:0] offs;
    offs = 9'd0;
    if (mon inside {[1:12]}) begin
      case (mon[3:0])
        4'd2:    offs = 9'd31;
        4'd3:    offs = leap ? 9'd60  : 9'd59;
        4'd4:    offs = leap ? 9'd91  : 9'd90;
        4'd5:    offs = leap ? 9'd121 : 9'd120;
        4'd6:    offs = leap ? 9'd152 : 9'd151;
        4'd7:    offs = leap ? 9'd182 : 9'd181;
        4'd8:    offs = leap ? 9'd213 : 9'd212;
        4'd9:    offs = leap ? 9'd244 : 9'd243;
        4'd10:   offs = leap ? 9'd274 : 9'd273;
        4'd11:   offs = leap ? 9'd305 : 9'd304;
        4'd12:   offs = leap ? 9'd335 : 9'd334;
        default: offs = 9'd0;
      endcase
    end
    return offs;
  endfunction

endpackage

// ===== rtl/core/dtem_decode.sv =====
`timescale 1ns / 1ps

module dtem_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [dtem_pkg::DateW-1:0]  date_i,
  input  logic [dtem_pkg::TimeW-1:0]  time_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output dtem_pkg::dec_t              data_o
);

  logic [3:0]     dn [8];
  logic [3:0]     tn [4];
  dtem_pkg::dec_t data_d, data_q;
  logic           valid_q;

  // Take the low nibble of each character, first character in the top byte
  always_comb begin
    for (int p = 0; p < 8; p++) dn[p] = date_i[8*(7-p) +: 4];
    for (int p = 0; p < 4; p++) tn[p] = time_i[8*(3-p) +: 4];
  end

  always_comb begin
    data_d.year = dtem_pkg::YearW'(dn[0]) * dtem_pkg::YearW'(1000)
                + dtem_pkg::YearW'(dn[1]) * dtem_pkg::YearW'(100)
                + dtem_pkg::YearW'(dn[2]) * dtem_pkg::YearW'(10)
                + dtem_pkg::YearW'(dn[3]);
    data_d.mon  = dtem_pkg::MonW'(dn[4]) * dtem_pkg::MonW'(10) + dtem_pkg::MonW'(dn[5]);
    data_d.mday = dtem_pkg::DayW'(dn[6]) * dtem_pkg::DayW'(10) + dtem_pkg::DayW'(dn[7]);
    data_d.mins = dtem_pkg::MinW'(tn[0]) * dtem_pkg::MinW'(600)
                + dtem_pkg::MinW'(tn[1]) * dtem_pkg::MinW'(60)
                + dtem_pkg::MinW'(tn[2]) * dtem_pkg::MinW'(10)
                + dtem_pkg::MinW'(tn[3]);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/dtem_split.sv =====
`timescale 1ns / 1ps

module dtem_split (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  dtem_pkg::dec_t   data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output dtem_pkg::split_t data_o
);

  localparam int unsigned ProdW = dtem_pkg::YearW + dtem_pkg::Recip100W;

  logic [ProdW-1:0] rest_prod, year_prod;
  dtem_pkg::split_t data_d, data_q;
  logic             valid_q;

  always_comb begin
    data_d.year_zero = (data_i.year == '0);
    data_d.year      = data_i.year;
    data_d.rest      = data_d.year_zero ? '0 : data_i.year - dtem_pkg::YearW'(1);
    // Divide by 100 through the reciprocal
    rest_prod = ProdW'(data_d.rest) * ProdW'(dtem_pkg::Recip100);
    year_prod = ProdW'(data_i.year) * ProdW'(dtem_pkg::Recip100);
    data_d.rest_q100 = rest_prod[dtem_pkg::Recip100Shift +: dtem_pkg::Q100W];
    data_d.year_q100 = year_prod[dtem_pkg::Recip100Shift +: dtem_pkg::Q100W];
    data_d.mon  = data_i.mon;
    data_d.mday = data_i.mday;
    data_d.mins = data_i.mins;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/dtem_days.sv =====
`timescale 1ns / 1ps

module dtem_days (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  dtem_pkg::split_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output dtem_pkg::days_t  data_o
);

  logic [dtem_pkg::YearW-1:0] year_c100;
  logic                       leap;
  logic [dtem_pkg::OutW-1:0]  year_days;
  dtem_pkg::days_t            data_d, data_q;
  logic                       valid_q;

  always_comb begin
    year_c100 = dtem_pkg::YearW'(data_i.year_q100) * dtem_pkg::YearW'(100);
    // Leap when divisible by 4 and not by 100, or divisible by 400
    leap = (data_i.year[1:0] == 2'b00)
        && ((year_c100 != data_i.year) || (data_i.year_q100[1:0] == 2'b00));
    // 365 r + r/4 - r/100 + r/400 equals the 400/100/4/1-year group sum
    if (data_i.year_zero) begin
      year_days = dtem_pkg::YearZeroDays;
    end else begin
      year_days = dtem_pkg::OutW'(data_i.rest) * dtem_pkg::DaysPerYear
                + dtem_pkg::OutW'(data_i.rest >> 2)
                - dtem_pkg::OutW'(data_i.rest_q100)
                + dtem_pkg::OutW'(data_i.rest_q100 >> 2);
    end
    data_d.days = year_days
                + dtem_pkg::OutW'(dtem_pkg::month_start(leap, data_i.mon))
                + dtem_pkg::OutW'(data_i.mday);
    data_d.mins = data_i.mins;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/dtem_scale.sv =====
`timescale 1ns / 1ps

module dtem_scale (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  dtem_pkg::days_t            data_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [dtem_pkg::OutW-1:0]  data_o
);

  logic [dtem_pkg::OutW-1:0] res_d, res_q;
  logic                      valid_q;

  // Wrap modulo 2^32 by keeping the low word
  assign res_d = data_i.days * dtem_pkg::MinPerDay + dtem_pkg::OutW'(data_i.mins);

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = res_q;

endmodule

// ===== rtl/core/date_time_to_epoch_minutes_top.sv =====
// Beats pass the decode, split, days and scale registers in turn to the master side.
// Throughput: one beat per cycle; each of the four stages holds one beat and moves
// it on as soon as the next stage has room, so bubbles close up under a stall.
// Reset: rst_ni clears all stage valid bits asynchronously; payload registers are
// not reset. No state carries over between beats.
`timescale 1ns / 1ps

module date_time_to_epoch_minutes_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side: tdata[63:0] = date_text, tdata[95:64] = time_text
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,
  // Master side: tdata[31:0] = epoch_minutes_out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o
);

  // Stage handshakes: each stage asserts ready while its register is empty or
  // the stage after it takes the held beat this cycle.
  logic             dec_valid, dec_ready;
  logic             spl_valid, spl_ready;
  logic             day_valid, day_ready;
  dtem_pkg::dec_t   dec_data;
  dtem_pkg::split_t spl_data;
  dtem_pkg::days_t  day_data;

  // Stage 1: turn characters into year, month, day and minute-of-day numbers.
  dtem_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .date_i  (s_axis_tdata_i[63:0]),
    .time_i  (s_axis_tdata_i[95:64]),
    .valid_o (dec_valid),
    .ready_i (dec_ready),
    .data_o  (dec_data)
  );

  // Stage 2: form year - 1 and divide it and the year by 100 via reciprocal.
  // Year zero is flagged here; its one-year group is minus one year.
  dtem_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .data_i  (dec_data),
    .valid_o (spl_valid),
    .ready_i (spl_ready),
    .data_o  (spl_data)
  );

  // Stage 3: sum the whole-year days, the month offset from the leap-aware
  // table and the day of month, all modulo 2^32.
  dtem_days u_days (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (spl_valid),
    .ready_o (spl_ready),
    .data_i  (spl_data),
    .valid_o (day_valid),
    .ready_i (day_ready),
    .data_o  (day_data)
  );

  // Stage 4: scale days to minutes and add the minute of day; this register
  // is the output register of the master side.
  dtem_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (day_valid),
    .ready_o (day_ready),
    .data_i  (day_data),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o)
  );

endmodule
